// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the partial annulus intersect block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/core/rpa_pkg.sv
// Package of the partial annulus intersect block: widths, codes, tables and payload types.
`timescale 1ns / 1ps

package rpa_pkg;

   // coordinate and field widths
   localparam int CRD_W    = 16;
   localparam int DIST_W   = 32;
   localparam int CFG_W    = 48;
   localparam int IDX_W    = 3;
   localparam int AZ_W     = 16;
   localparam int REQ_W    = 6 * CRD_W;
   localparam int RSP_W    = DIST_W + 3 * CRD_W;

   // hit distance must exceed this raw Q16.16 value
   localparam int unsigned T_EPSILON = 7;

   // operation codes carried on req_tuser
   localparam logic OP_PRIMARY = 1'b0;
   localparam logic OP_SHADOW  = 1'b1;

   // arithmetic widths through the pipeline
   localparam int DIFF_W   = CRD_W + 1;          // c - o
   localparam int NPROD_W  = DIFF_W + CRD_W;     // (c - o) * n
   localparam int DPROD_W  = 2 * CRD_W;          // d * n
   localparam int NUM_W    = NPROD_W + 2;        // sum of three
   localparam int DEN_W    = DPROD_W + 2;
   localparam int NMAG_W   = 33;                 // |num| stays below 2^33
   localparam int DMAG_W   = 32;                 // |den| stays below 2^32
   localparam int FRAC_W   = 16;
   localparam int DIV_STEPS = NMAG_W + FRAC_W;   // quotient bits
   localparam int TC_SHIFT = 40;                 // t clamp at 2^40
   localparam int TC_W     = TC_SHIFT + 1;
   localparam int TC_LO_W  = 24;
   localparam int TC_HI_W  = TC_W - TC_LO_W;
   localparam int PLO_W    = TC_LO_W + 1 + CRD_W;
   localparam int PHI_W    = TC_HI_W + 1 + CRD_W;
   localparam int PROD_W   = PHI_W + TC_LO_W;
   localparam int P_W      = PROD_W - FRAC_W;
   localparam int DD_W     = P_W + 1;
   localparam int DSQ_IN_W = 17;                 // |p - c| below 2^16 when in range
   localparam int SQ_W     = 32;
   localparam int V_W      = SQ_W + 2;
   localparam int CX_W     = 18;                 // hit point bits fed to the angle unit
   localparam int CRD_SCL  = 14;                 // pre-scale by 16384
   localparam int XY_W     = 36;
   localparam int ANG_W    = 27;
   localparam int ANG_HALF = 23;                 // half turn in 2^-24 turns
   localparam int ANG_RND  = 128;
   localparam int ANG_DROP = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_W   = 22;

   // fixed azimuths for points on an axis
   localparam logic [AZ_W-1:0] AZ_ZERO  = 16'd0;
   localparam logic [AZ_W-1:0] AZ_QUART = 16'd16384;
   localparam logic [AZ_W-1:0] AZ_HALF  = 16'd32768;
   localparam logic [AZ_W-1:0] AZ_3QUAR = 16'd49152;

   // register indexes of the configuration port
   typedef enum logic [IDX_W-1:0] {
      REG_CENTER  = 3'd0,
      REG_NORMAL  = 3'd1,
      REG_INNER   = 3'd2,
      REG_OUTER   = 3'd3,
      REG_AZ_MIN  = 3'd4,
      REG_AZ_MAX  = 3'd5,
      REG_SHADOWS = 3'd6
   } reg_index_type;

   // reset values of the registers
   localparam logic [CFG_W-1:0]  RST_CENTER  = 48'd0;
   localparam logic [CFG_W-1:0]  RST_NORMAL  = 48'd256;
   localparam logic [DIST_W-1:0] RST_INNER   = 32'd65536;
   localparam logic [DIST_W-1:0] RST_OUTER   = 32'd262144;
   localparam logic [AZ_W-1:0]   RST_AZ_MIN  = 16'd0;
   localparam logic [AZ_W-1:0]   RST_AZ_MAX  = 16'd65535;

   // arctangent of 2^-i in 2^-24 turns
   localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
      22'd166669,  22'd83416,   22'd41718,  22'd20860,
      22'd10430,   22'd5215,    22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81
   };

   // ray data carried through the head of the pipeline
   typedef struct packed {
      logic                   alive;
      logic [2:0][CRD_W-1:0]  o;
      logic [2:0][CRD_W-1:0]  d;
   } ray_type;

   // result data carried through the tail of the pipeline
   typedef struct packed {
      logic                   alive;
      logic [DIST_W-1:0]      tsat;
      logic [2:0][CRD_W-1:0]  psat;
   } tail_type;

   // axis cases of the hit point for the azimuth
   typedef struct packed {
      logic sx_zero;
      logic sx_pos;
      logic cz_zero;
      logic cz_neg;
   } axis_type;

endpackage

// File: rtl/core/ray_part_annulus_intersect.sv
// Top level of the ray versus partial annulus intersect pipeline.
`timescale 1ns / 1ps

// Ray versus partial annulus intersect. One ray word enters per cycle and one
// result word leaves per ray, in order. The pipeline is 76 stages deep: two
// product and sum stages, one sign stage, a 49-stage restoring divider (one
// quotient bit per stage), seven stages for the hit point and radius test, a
// 16-stage CORDIC for the azimuth and the output register. The whole
// pipeline holds while a result word waits on rsp_tready, so the sustained
// rate is one ray per cycle whenever the result side keeps taking words.
// A miss returns zero distance and zero point. The user must write
// configuration through the csr_ port only while no ray is in flight; the
// block itself does not enforce it.

`include "assert_macros.svh"

module ray_part_annulus_intersect (
   input  logic                        clock,
   input  logic                        reset,
   // ray words
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
   input  logic [rpa_pkg::REQ_W-1:0]   req_tdata,
   // operation
   input  logic                        req_tuser,
   // result words
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // hit_distance, hit_x, hit_y, hit_z
   output logic [rpa_pkg::RSP_W-1:0]   rsp_tdata,
   // hit
   output logic                        rsp_tuser,
   // register writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rpa_pkg::IDX_W-1:0]   csr_index,
   input  logic [rpa_pkg::CFG_W-1:0]   csr_data
);
   import rpa_pkg::*;

   // ------------------------------------------------------------------
   // configuration registers
   logic [CFG_W-1:0]  center_ff, normal_ff;
   logic [DIST_W-1:0] inner_ff, outer_ff;
   logic [AZ_W-1:0]   az_min_ff, az_max_ff;
   logic              shadows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff  <= RST_CENTER;
         normal_ff  <= RST_NORMAL;
         inner_ff   <= RST_INNER;
         outer_ff   <= RST_OUTER;
         az_min_ff  <= RST_AZ_MIN;
         az_max_ff  <= RST_AZ_MAX;
         shadows_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_CENTER:  center_ff  <= csr_data;
            REG_NORMAL:  normal_ff  <= csr_data;
            REG_INNER:   inner_ff   <= csr_data[DIST_W-1:0];
            REG_OUTER:   outer_ff   <= csr_data[DIST_W-1:0];
            REG_AZ_MIN:  az_min_ff  <= csr_data[AZ_W-1:0];
            REG_AZ_MAX:  az_max_ff  <= csr_data[AZ_W-1:0];
            REG_SHADOWS: shadows_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic signed [CRD_W-1:0] cen [3];
   logic signed [CRD_W-1:0] nrm [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cen[i] = $signed(center_ff[CRD_W*i +: CRD_W]);
         nrm[i] = $signed(normal_ff[CRD_W*i +: CRD_W]);
      end
   end

   // ------------------------------------------------------------------
   // pipeline advance: every stage moves when the output slot is free
   logic adv;
   logic rsp_vld_ff;

   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   // ------------------------------------------------------------------
   // stage 1: plane products
   logic signed [DIFF_W-1:0]  diff_w  [3];
   logic signed [NPROD_W-1:0] nprod_in [3];
   logic signed [DPROD_W-1:0] dprod_in [3];
   ray_type                   ray1_in;

   always_comb begin
      ray1_in.alive = !((req_tuser == OP_SHADOW) && !shadows_ff);
      for (int i = 0; i < 3; i++) begin
         ray1_in.o[i] = req_tdata[CRD_W*i +: CRD_W];
         ray1_in.d[i] = req_tdata[CRD_W*(i+3) +: CRD_W];
         diff_w[i]    = DIFF_W'(cen[i]) - DIFF_W'($signed(ray1_in.o[i]));
         nprod_in[i]  = diff_w[i] * nrm[i];
         dprod_in[i]  = $signed(ray1_in.d[i]) * nrm[i];
      end
   end

   logic                      s1_vld_ff;
   ray_type                   s1_ray_ff;
   logic signed [NPROD_W-1:0] s1_nprod_ff [3];
   logic signed [DPROD_W-1:0] s1_dprod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ray_ff   <= ray1_in;
         s1_nprod_ff <= nprod_in;
         s1_dprod_ff <= dprod_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: numerator and denominator sums
   logic                    s2_vld_ff;
   ray_type                 s2_ray_ff;
   logic signed [NUM_W-1:0] s2_num_ff;
   logic signed [DEN_W-1:0] s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (adv) s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ray_ff <= s1_ray_ff;
         s2_num_ff <= NUM_W'(s1_nprod_ff[0]) + NUM_W'(s1_nprod_ff[1])
                    + NUM_W'(s1_nprod_ff[2]);
         s2_den_ff <= DEN_W'(s1_dprod_ff[0]) + DEN_W'(s1_dprod_ff[1])
                    + DEN_W'(s1_dprod_ff[2]);
      end
   end

   // ------------------------------------------------------------------
   // stage 3: magnitudes and sign test, divider input
   logic                div_vld_ff [DIV_STEPS+1];
   ray_type             div_ray_ff [DIV_STEPS+1];
   logic [DMAG_W-1:0]   div_rem_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] div_dq_ff [DIV_STEPS+1];
   logic [DMAG_W-1:0]   div_den_ff [DIV_STEPS+1];

   logic              num_neg, den_neg;
   logic [NUM_W-1:0]  nmag_w;
   logic [DEN_W-1:0]  dmag_w;
   ray_type           ray3_in;

   always_comb begin
      num_neg       = s2_num_ff[NUM_W-1];
      den_neg       = s2_den_ff[DEN_W-1];
      nmag_w        = num_neg ? NUM_W'(-s2_num_ff) : NUM_W'(s2_num_ff);
      dmag_w        = den_neg ? DEN_W'(-s2_den_ff) : DEN_W'(s2_den_ff);
      ray3_in       = s2_ray_ff;
      // t must be positive: nonzero denominator and equal signs
      ray3_in.alive = s2_ray_ff.alive && (s2_den_ff != '0) && (num_neg == den_neg);
   end

   always_ff @(posedge clock) begin
      if (reset) div_vld_ff[0] <= 1'b0;
      else if (adv) div_vld_ff[0] <= s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ray_ff[0] <= ray3_in;
         div_rem_ff[0] <= '0;
         div_dq_ff[0]  <= {nmag_w[NMAG_W-1:0], FRAC_W'(0)};
         div_den_ff[0] <= dmag_w[DMAG_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // restoring divider, one quotient bit per stage
   for (genvar gk = 1; gk <= DIV_STEPS; gk++) begin : g_div
      logic [DMAG_W:0]   shift_w;
      logic [DMAG_W+1:0] trial_w;

      always_comb begin
         shift_w = {div_rem_ff[gk-1], div_dq_ff[gk-1][DIV_STEPS-1]};
         trial_w = {1'b0, shift_w} - {2'b0, div_den_ff[gk-1]};
      end

      always_ff @(posedge clock) begin
         if (reset) div_vld_ff[gk] <= 1'b0;
         else if (adv) div_vld_ff[gk] <= div_vld_ff[gk-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ray_ff[gk] <= div_ray_ff[gk-1];
            div_den_ff[gk] <= div_den_ff[gk-1];
            div_rem_ff[gk] <= trial_w[DMAG_W+1] ? shift_w[DMAG_W-1:0]
                                                : trial_w[DMAG_W-1:0];
            div_dq_ff[gk]  <= {div_dq_ff[gk-1][DIV_STEPS-2:0], !trial_w[DMAG_W+1]};
         end
      end
   end

   // ------------------------------------------------------------------
   // stage T: epsilon test, clamp and saturate t
   logic [DIV_STEPS-1:0] quot_w;
   ray_type              rayt_in;

   always_comb begin
      quot_w        = div_dq_ff[DIV_STEPS];
      rayt_in       = div_ray_ff[DIV_STEPS];
      rayt_in.alive = div_ray_ff[DIV_STEPS].alive
                   && (quot_w > DIV_STEPS'(T_EPSILON));
   end

   logic              st_vld_ff;
   ray_type           st_ray_ff;
   logic [TC_W-1:0]   st_tc_ff;
   logic [DIST_W-1:0] st_tsat_ff;

   always_ff @(posedge clock) begin
      if (reset) st_vld_ff <= 1'b0;
      else if (adv) st_vld_ff <= div_vld_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ray_ff  <= rayt_in;
         st_tc_ff   <= (quot_w > (DIV_STEPS'(1) << TC_SHIFT))
                     ? (TC_W'(1) << TC_SHIFT) : quot_w[TC_W-1:0];
         st_tsat_ff <= (|quot_w[DIV_STEPS-1:DIST_W]) ? '1 : quot_w[DIST_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // stage A: partial products of t times direction
   logic signed [PLO_W-1:0] plo_in [3];
   logic signed [PHI_W-1:0] phi_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         plo_in[i] = $signed({1'b0, st_tc_ff[TC_LO_W-1:0]}) * $signed(st_ray_ff.d[i]);
         phi_in[i] = $signed({1'b0, st_tc_ff[TC_W-1:TC_LO_W]}) * $signed(st_ray_ff.d[i]);
      end
   end

   logic                    sa_vld_ff;
   ray_type                 sa_ray_ff;
   logic [DIST_W-1:0]       sa_tsat_ff;
   logic signed [PLO_W-1:0] sa_plo_ff [3];
   logic signed [PHI_W-1:0] sa_phi_ff [3];

   always_ff @(posedge clock) begin
      if (reset) sa_vld_ff <= 1'b0;
      else if (adv) sa_vld_ff <= st_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ray_ff  <= st_ray_ff;
         sa_tsat_ff <= st_tsat_ff;
         sa_plo_ff  <= plo_in;
         sa_phi_ff  <= phi_in;
      end
   end

   // ------------------------------------------------------------------
   // stage B: full products
   logic                     sb_vld_ff;
   ray_type                  sb_ray_ff;
   logic [DIST_W-1:0]        sb_tsat_ff;
   logic signed [PROD_W-1:0] sb_prod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) sb_vld_ff <= 1'b0;
      else if (adv) sb_vld_ff <= sa_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ray_ff  <= sa_ray_ff;
         sb_tsat_ff <= sa_tsat_ff;
         for (int i = 0; i < 3; i++)
            sb_prod_ff[i] <= $signed({sa_phi_ff[i], TC_LO_W'(0)})
                           + PROD_W'(sa_plo_ff[i]);
      end
   end

   // ------------------------------------------------------------------
   // stage C: hit point and its saturated form
   logic signed [P_W-1:0]  p_in   [3];
   logic [CRD_W-1:0]       psat_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = P_W'($signed(sb_ray_ff.o[i])) + $signed(sb_prod_ff[i][PROD_W-1:FRAC_W]);
         if (p_in[i] > P_W'(32767))
            psat_in[i] = 16'h7FFF;
         else if (p_in[i] < -P_W'(32768))
            psat_in[i] = 16'h8000;
         else
            psat_in[i] = p_in[i][CRD_W-1:0];
      end
   end

   logic                  sc_vld_ff;
   tail_type              sc_tail_ff;
   logic signed [P_W-1:0] sc_p_ff [3];

   always_ff @(posedge clock) begin
      if (reset) sc_vld_ff <= 1'b0;
      else if (adv) sc_vld_ff <= sb_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_tail_ff.alive <= sb_ray_ff.alive;
         sc_tail_ff.tsat  <= sb_tsat_ff;
         for (int i = 0; i < 3; i++)
            sc_tail_ff.psat[i] <= psat_in[i];
         sc_p_ff <= p_in;
      end
   end

   // ------------------------------------------------------------------
   // stage D: offset from center, far point test
   logic signed [DD_W-1:0] dd_w [3];
   logic                   far_w;

   always_comb begin
      far_w = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dd_w[i] = DD_W'(sc_p_ff[i]) - DD_W'(cen[i]);
         if (dd_w[i] >= DD_W'(65536) || dd_w[i] <= -DD_W'(65536))
            far_w = 1'b1;
      end
   end

   logic                       sd_vld_ff;
   tail_type                   sd_tail_ff;
   logic signed [DSQ_IN_W-1:0] sd_dd_ff [3];
   logic signed [CX_W-1:0]     sd_px_ff, sd_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) sd_vld_ff <= 1'b0;
      else if (adv) sd_vld_ff <= sc_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_tail_ff.alive <= sc_tail_ff.alive && !far_w;
         sd_tail_ff.tsat  <= sc_tail_ff.tsat;
         sd_tail_ff.psat  <= sc_tail_ff.psat;
         for (int i = 0; i < 3; i++)
            sd_dd_ff[i] <= dd_w[i][DSQ_IN_W-1:0];
         sd_px_ff <= sc_p_ff[0][CX_W-1:0];
         sd_pz_ff <= sc_p_ff[2][CX_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // stage E: squares
   logic signed [2*DSQ_IN_W-1:0] sq_w [3];

   always_comb begin
      for (int i = 0; i < 3; i++)
         sq_w[i] = sd_dd_ff[i] * sd_dd_ff[i];
   end

   logic                   se_vld_ff;
   tail_type               se_tail_ff;
   logic [SQ_W-1:0]        se_sq_ff [3];
   logic signed [CX_W-1:0] se_px_ff, se_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) se_vld_ff <= 1'b0;
      else if (adv) se_vld_ff <= sd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         se_tail_ff <= sd_tail_ff;
         for (int i = 0; i < 3; i++)
            se_sq_ff[i] <= sq_w[i][SQ_W-1:0];
         se_px_ff <= sd_px_ff;
         se_pz_ff <= sd_pz_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage F: radius test and angle unit pre-rotation
   logic                    cr_vld_ff  [CORDIC_STEPS+1];
   tail_type                cr_tail_ff [CORDIC_STEPS+1];
   axis_type                cr_axis_ff [CORDIC_STEPS+1];
   logic signed [XY_W-1:0]  cr_x_ff    [CORDIC_STEPS+1];
   logic signed [XY_W-1:0]  cr_y_ff    [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] cr_ang_ff  [CORDIC_STEPS+1];

   logic [V_W-1:0]         v_w;
   logic signed [XY_W-1:0] cx_w, cy_w;
   axis_type               axis_in;

   always_comb begin
      v_w  = V_W'(se_sq_ff[0]) + V_W'(se_sq_ff[1]) + V_W'(se_sq_ff[2]);
      cx_w = XY_W'(se_pz_ff) <<< CRD_SCL;
      cy_w = XY_W'(se_px_ff) <<< CRD_SCL;
      axis_in.sx_zero = (se_px_ff == '0);
      axis_in.sx_pos  = !se_px_ff[CX_W-1] && (se_px_ff != '0);
      axis_in.cz_zero = (se_pz_ff == '0);
      axis_in.cz_neg  = se_pz_ff[CX_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) cr_vld_ff[0] <= 1'b0;
      else if (adv) cr_vld_ff[0] <= se_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr_tail_ff[0].alive <= se_tail_ff.alive && (v_w > V_W'(inner_ff))
                             && (v_w < V_W'(outer_ff));
         cr_tail_ff[0].tsat  <= se_tail_ff.tsat;
         cr_tail_ff[0].psat  <= se_tail_ff.psat;
         cr_axis_ff[0]       <= axis_in;
         // left half plane: turn by half a turn first
         if (cx_w < 0) begin
            cr_x_ff[0]   <= -cx_w;
            cr_y_ff[0]   <= -cy_w;
            cr_ang_ff[0] <= ANG_W'(1) <<< ANG_HALF;
         end else begin
            cr_x_ff[0]   <= cx_w;
            cr_y_ff[0]   <= cy_w;
            cr_ang_ff[0] <= '0;
         end
      end
   end

   // ------------------------------------------------------------------
   // CORDIC vectoring, one micro-rotation per stage
   for (genvar gi = 1; gi <= CORDIC_STEPS; gi++) begin : g_cordic
      localparam int SH = gi - 1;
      logic signed [ANG_W-1:0] step_w;

      assign step_w = $signed(ANG_W'(ATAN_TAB[SH]));

      always_ff @(posedge clock) begin
         if (reset) cr_vld_ff[gi] <= 1'b0;
         else if (adv) cr_vld_ff[gi] <= cr_vld_ff[gi-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cr_tail_ff[gi] <= cr_tail_ff[gi-1];
            cr_axis_ff[gi] <= cr_axis_ff[gi-1];
            if (!cr_y_ff[gi-1][XY_W-1]) begin
               cr_x_ff[gi]   <= cr_x_ff[gi-1] + (cr_y_ff[gi-1] >>> SH);
               cr_y_ff[gi]   <= cr_y_ff[gi-1] - (cr_x_ff[gi-1] >>> SH);
               cr_ang_ff[gi] <= cr_ang_ff[gi-1] + step_w;
            end else begin
               cr_x_ff[gi]   <= cr_x_ff[gi-1] - (cr_y_ff[gi-1] >>> SH);
               cr_y_ff[gi]   <= cr_y_ff[gi-1] + (cr_x_ff[gi-1] >>> SH);
               cr_ang_ff[gi] <= cr_ang_ff[gi-1] - step_w;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // output stage: round azimuth, sector test, result word
   logic signed [ANG_W-1:0] ang_rnd_w;
   logic [AZ_W-1:0]         phi_w;
   logic                    hit_w;
   tail_type                tail_w;
   axis_type                axis_w;

   always_comb begin
      tail_w    = cr_tail_ff[CORDIC_STEPS];
      axis_w    = cr_axis_ff[CORDIC_STEPS];
      ang_rnd_w = cr_ang_ff[CORDIC_STEPS] + $signed(ANG_W'(ANG_RND));
      phi_w     = ang_rnd_w[ANG_DROP +: AZ_W];
      priority if (axis_w.sx_zero)
         phi_w = axis_w.cz_neg ? AZ_HALF : AZ_ZERO;
      else if (axis_w.cz_zero)
         phi_w = axis_w.sx_pos ? AZ_QUART : AZ_3QUAR;
      hit_w = tail_w.alive && (phi_w >= az_min_ff) && (phi_w <= az_max_ff);
   end

   logic                    rsp_hit_ff;
   logic [DIST_W-1:0]       rsp_dist_ff;
   logic [2:0][CRD_W-1:0]   rsp_p_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (adv) rsp_vld_ff <= cr_vld_ff[CORDIC_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff  <= hit_w;
         rsp_dist_ff <= hit_w ? tail_w.tsat : '0;
         rsp_p_ff    <= hit_w ? tail_w.psat : '0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {rsp_p_ff[2], rsp_p_ff[1], rsp_p_ff[0], rsp_dist_ff};

   // ------------------------------------------------------------------
   // checks
   `ASSERT_IMPL(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `ASSERT_IMPL(a_hit_far, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[DIST_W-1:0] > DIST_W'(T_EPSILON))
   `ASSERT_IMPL(a_stall_in, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, s1_vld_ff)

endmodule
